// File: rtl/acit_pkg.sv
// ----------------------------------------------------------------------------
// acit_pkg
// shared codes, register page addresses, wait tables and timer control type
// ----------------------------------------------------------------------------
package acit_pkg;

  // item kinds
  localparam logic [2:0] FUNC_IDLE    = 3'd0;
  localparam logic [2:0] FUNC_CPU_RD  = 3'd1;
  localparam logic [2:0] FUNC_CPU_WR  = 3'd2;
  localparam logic [2:0] FUNC_HOST_WR = 3'd3;
  localparam logic [2:0] FUNC_HOST_RD = 3'd4;

  // register page
  localparam logic [15:0] PAGE_MASK   = 16'hfff0;
  localparam logic [15:0] PAGE_BASE   = 16'h00f0;
  localparam logic [15:0] PORT_MASK   = 16'hfffc;
  localparam logic [15:0] PORT_BASE   = 16'h00f4;
  localparam logic [15:0] BOOT_ROM_LO = 16'hffc0;

  localparam logic [7:0] REG_TEST    = 8'hf0;
  localparam logic [7:0] REG_CONTROL = 8'hf1;
  localparam logic [7:0] REG_DSP_ADR = 8'hf2;
  localparam logic [7:0] REG_DSP_DAT = 8'hf3;
  localparam logic [7:0] REG_PORT0   = 8'hf4;
  localparam logic [7:0] REG_PORT1   = 8'hf5;
  localparam logic [7:0] REG_PORT2   = 8'hf6;
  localparam logic [7:0] REG_PORT3   = 8'hf7;
  localparam logic [7:0] REG_AUX0    = 8'hf8;
  localparam logic [7:0] REG_AUX1    = 8'hf9;
  localparam logic [7:0] REG_TARGET0 = 8'hfa;
  localparam logic [7:0] REG_OUT0    = 8'hfd;
  localparam logic [7:0] REG_OUT1    = 8'hfe;
  localparam logic [7:0] REG_OUT2    = 8'hff;

  localparam logic [7:0] RAM_FILL = 8'h5a;

  localparam int TIMER_NUM = 3;

  // half-clocks per access and timer clocks per access, by wait select
  localparam logic [4:0] CPU_WAIT [4] = '{5'd2, 5'd4, 5'd10, 5'd20};
  localparam logic [4:0] TMR_WAIT [4] = '{5'd2, 5'd4, 5'd8, 5'd16};

  // per-timer control for one item
  typedef struct packed {
    logic       step;      // item is retired this cycle
    logic [4:0] clocks1;   // timer clocks before the access
    logic [4:0] clocks2;   // timer clocks after the access
    logic       run_old;   // timers running before a TEST write
    logic       pulse;     // TEST write re-evaluates the phase line
    logic       run_new;   // timers running after the TEST write
    logic       on_wr;     // CONTROL write
    logic       on_val;
    logic       tgt_wr;    // target write
    logic [7:0] tgt_val;
    logic       rd_clr;    // output read, clear afterwards
  } tmr_ctl_t;

endpackage

// File: rtl/acit_timer.sv
// ----------------------------------------------------------------------------
// acit_timer
// one prescaled timer: prescaler, phase line, falling-edge counter, output
// ----------------------------------------------------------------------------
module acit_timer #(
  parameter int PERIOD = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  acit_pkg::tmr_ctl_t ctl,
  output logic [3:0]         out_value
);

  localparam logic [8:0] PERIOD_W = 9'(PERIOD);

  typedef struct packed {
    logic [7:0] pre;
    logic       phase;
    logic       edge_line;
    logic       on;
    logic [7:0] target;
    logic [7:0] count;
    logic [3:0] outv;
  } tmr_state_t;

  tmr_state_t st;
  tmr_state_t st_adv1;
  tmr_state_t st_adv2;
  tmr_state_t st_next;

  function automatic tmr_state_t tmr_pulse(tmr_state_t s, logic run);
    tmr_state_t r;
    logic       level;
    logic       falling;
    logic [7:0] cnt_inc;
    r       = s;
    level   = s.phase & run;
    falling = s.edge_line & ~level;
    cnt_inc = s.count + 8'd1;
    r.edge_line = level;
    if (falling && s.on) begin
      if (cnt_inc == s.target) begin
        r.count = 8'd0;
        r.outv  = s.outv + 4'd1;
      end else begin
        r.count = cnt_inc;
      end
    end
    return r;
  endfunction

  function automatic tmr_state_t tmr_advance(tmr_state_t s, logic [4:0] clocks, logic run);
    tmr_state_t r;
    logic [8:0] acc;
    r   = s;
    acc = {1'b0, s.pre} + {4'b0000, clocks};
    if (acc >= PERIOD_W) begin
      r.pre   = 8'(acc - PERIOD_W);
      r.phase = ~s.phase;
      r       = tmr_pulse(r, run);
    end else begin
      r.pre   = acc[7:0];
    end
    return r;
  endfunction

  always_comb begin
    st_adv1 = tmr_advance(st, ctl.clocks1, ctl.run_old);
    st_adv2 = tmr_advance(st_adv1, ctl.clocks2, ctl.run_old);
    st_next = st_adv2;
    if (ctl.rd_clr) begin
      st_next.outv = 4'd0;
    end
    if (ctl.pulse) begin
      st_next = tmr_pulse(st_next, ctl.run_new);
    end
    if (ctl.on_wr) begin
      if (!st_next.on && ctl.on_val) begin
        st_next.count = 8'd0;
        st_next.outv  = 4'd0;
      end
      st_next.on = ctl.on_val;
    end
    if (ctl.tgt_wr) begin
      st_next.target = ctl.tgt_val;
    end
  end

  // value seen by an output read: after this item's clocks, before the clear
  assign out_value = st_adv2.outv;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (ctl.step) begin
      st <= st_next;
    end
  end

endmodule

// File: rtl/audio_cpu_io_page_and_timers_core.sv
// ----------------------------------------------------------------------------
// audio_cpu_io_page_and_timers_core
// register page and three prescaled timers of a sound processor
// ----------------------------------------------------------------------------
// pipeline: input register, then result register
// throughput: one request per cycle unless the result is stalled; each item is one
//   combinational pass between input and result registers, state written in that pass
// reset: synchronous, active high; clears both stream stages and sets the page
//   to its power-on values (ram writable, timers enabled, boot rom enabled)
// ----------------------------------------------------------------------------
module audio_cpu_io_page_and_timers_core #(
  parameter int SLOW_TIMER_PERIOD = 128,
  parameter int FAST_TIMER_PERIOD = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input requests
  input  logic        s_tvalid,
  output logic        s_tready,
  // address[15:0], write_data[23:16], p_flag[24], dsp_read_data[32:25],
  // host_port[34:33], zero[39:35]
  input  logic [39:0] s_tdata,
  // func[2:0]
  input  logic [2:0]  s_tuser,
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0], io_hit[8], boot_rom_select[9], ram_read_forced[10],
  // ram_write_allowed[11], cpu_half_clocks[16:12], dsp_write[17],
  // dsp_register[24:18], dsp_write_value[32:25], zero[39:33]
  output logic [39:0] m_tdata
);

  // input stage
  logic        in_valid;
  logic [2:0]  in_func;
  logic [15:0] in_addr;
  logic [7:0]  in_wd;
  logic        in_pf;
  logic [7:0]  in_dsp_rd;
  logic [1:0]  in_port;
  logic        go;

  // page state
  logic [7:0] host_to_chip_port [4];
  logic [7:0] chip_to_host_port [4];
  logic [7:0] aux_byte [2];
  logic       timers_disable;
  logic       ram_writable;
  logic       ram_disable;
  logic       timers_enable;
  logic [1:0] external_wait_sel;
  logic [1:0] internal_wait_sel;
  logic       boot_rom_enable;
  logic [7:0] dsp_address;

  // decode
  logic       is_idle, is_rd, is_wr, is_hw, is_hr;
  logic       page, rom, split;
  logic [7:0] reg_sel;
  logic [1:0] ws;
  logic [4:0] tw;
  logic       wr_test, wr_control;

  acit_pkg::tmr_ctl_t tmr_ctl [acit_pkg::TIMER_NUM];
  logic [3:0]         tmr_out [acit_pkg::TIMER_NUM];

  // result fields
  logic [7:0] rd_data;
  logic       forced;
  logic [4:0] half_clocks;
  logic       dsp_wr;
  logic [6:0] dsp_reg;
  logic [7:0] dsp_val;
  logic [39:0] result;

  // an item moves on whenever the result register is free or being emptied
  assign go       = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func   <= s_tuser;
      in_addr   <= s_tdata[15:0];
      in_wd     <= s_tdata[23:16];
      in_pf     <= s_tdata[24];
      in_dsp_rd <= s_tdata[32:25];
      in_port   <= s_tdata[34:33];
    end
  end

  // item decode
  always_comb begin
    is_idle = in_func == acit_pkg::FUNC_IDLE;
    is_rd   = in_func == acit_pkg::FUNC_CPU_RD;
    is_wr   = in_func == acit_pkg::FUNC_CPU_WR;
    is_hw   = in_func == acit_pkg::FUNC_HOST_WR;
    is_hr   = in_func == acit_pkg::FUNC_HOST_RD;
    page    = (in_addr & acit_pkg::PAGE_MASK) == acit_pkg::PAGE_BASE;
    rom     = (in_addr >= acit_pkg::BOOT_ROM_LO) && boot_rom_enable;
    // port reads split their timer clocks around the access
    split   = is_rd && ((in_addr & acit_pkg::PORT_MASK) == acit_pkg::PORT_BASE);
    reg_sel = in_addr[7:0];
    // idle, page and boot rom use the internal wait select
    ws      = (is_idle || page || rom) ? internal_wait_sel : external_wait_sel;
    tw      = acit_pkg::TMR_WAIT[ws];
    wr_test    = is_wr && page && (reg_sel == acit_pkg::REG_TEST) && !in_pf;
    wr_control = is_wr && page && (reg_sel == acit_pkg::REG_CONTROL);
  end

  // timer controls
  always_comb begin
    for (int k = 0; k < acit_pkg::TIMER_NUM; k++) begin
      tmr_ctl[k].step    = go;
      tmr_ctl[k].clocks1 = (is_idle || is_rd || is_wr) ? (split ? (tw >> 1) : tw) : 5'd0;
      tmr_ctl[k].clocks2 = split ? (tw >> 1) : 5'd0;
      tmr_ctl[k].run_old = timers_enable && !timers_disable;
      tmr_ctl[k].pulse   = wr_test;
      tmr_ctl[k].run_new = in_wd[3] && !in_wd[0];
      tmr_ctl[k].on_wr   = wr_control;
      tmr_ctl[k].on_val  = in_wd[k];
      tmr_ctl[k].tgt_wr  = is_wr && page && (reg_sel == acit_pkg::REG_TARGET0 + 8'(k));
      tmr_ctl[k].tgt_val = in_wd;
      tmr_ctl[k].rd_clr  = is_rd && page && (reg_sel == acit_pkg::REG_OUT0 + 8'(k));
    end
  end

  for (genvar k = 0; k < acit_pkg::TIMER_NUM; k++) begin : g_timer
    acit_timer #(
      .PERIOD ((k == acit_pkg::TIMER_NUM - 1) ? FAST_TIMER_PERIOD : SLOW_TIMER_PERIOD)
    ) u_timer (
      .clk       (clk),
      .rst       (rst),
      .ctl       (tmr_ctl[k]),
      .out_value (tmr_out[k])
    );
  end

  // result fields
  always_comb begin
    rd_data     = 8'd0;
    forced      = 1'b0;
    half_clocks = 5'd0;
    dsp_wr      = 1'b0;
    dsp_reg     = 7'd0;
    dsp_val     = 8'd0;
    if (is_idle || is_rd || is_wr) begin
      half_clocks = acit_pkg::CPU_WAIT[ws];
    end
    if (is_rd) begin
      if (page) begin
        unique case (reg_sel) inside
          acit_pkg::REG_DSP_ADR: rd_data = dsp_address;
          acit_pkg::REG_DSP_DAT: begin
            rd_data = in_dsp_rd;
            dsp_reg = dsp_address[6:0];
          end
          acit_pkg::REG_PORT0, acit_pkg::REG_PORT1,
          acit_pkg::REG_PORT2, acit_pkg::REG_PORT3:
            rd_data = host_to_chip_port[reg_sel[1:0]];
          acit_pkg::REG_AUX0: rd_data = aux_byte[0];
          acit_pkg::REG_AUX1: rd_data = aux_byte[1];
          acit_pkg::REG_OUT0: rd_data = {4'd0, tmr_out[0]};
          acit_pkg::REG_OUT1: rd_data = {4'd0, tmr_out[1]};
          acit_pkg::REG_OUT2: rd_data = {4'd0, tmr_out[2]};
          default: rd_data = 8'd0;
        endcase
      end else if (!rom && ram_disable) begin
        // disabled ram reads back a fixed pattern
        forced  = 1'b1;
        rd_data = acit_pkg::RAM_FILL;
      end
    end else if (is_wr) begin
      if (page && (reg_sel == acit_pkg::REG_DSP_DAT)) begin
        dsp_reg = dsp_address[6:0];
        // upper half of the dsp address space is read-only
        dsp_wr  = !dsp_address[7];
        dsp_val = dsp_address[7] ? 8'd0 : in_wd;
      end
    end else if (is_hr) begin
      rd_data = chip_to_host_port[in_port];
    end
  end

  assign result = {7'd0, dsp_val, dsp_reg, dsp_wr, half_clocks,
                   is_wr && ram_writable && !ram_disable,
                   forced, is_rd && rom, (is_rd || is_wr) && page, rd_data};

  // page state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        host_to_chip_port[i] <= 8'd0;
        chip_to_host_port[i] <= 8'd0;
      end
      aux_byte[0]       <= 8'd0;
      aux_byte[1]       <= 8'd0;
      timers_disable    <= 1'b0;
      ram_writable      <= 1'b1;
      ram_disable       <= 1'b0;
      timers_enable     <= 1'b1;
      external_wait_sel <= 2'd0;
      internal_wait_sel <= 2'd0;
      boot_rom_enable   <= 1'b1;
      dsp_address       <= 8'd0;
    end else if (go) begin
      if (wr_test) begin
        timers_disable    <= in_wd[0];
        ram_writable      <= in_wd[1];
        ram_disable       <= in_wd[2];
        timers_enable     <= in_wd[3];
        external_wait_sel <= in_wd[5:4];
        internal_wait_sel <= in_wd[7:6];
      end
      if (wr_control) begin
        // port clear bits and boot rom switch
        if (in_wd[4]) begin
          host_to_chip_port[0] <= 8'd0;
          host_to_chip_port[1] <= 8'd0;
        end
        if (in_wd[5]) begin
          host_to_chip_port[2] <= 8'd0;
          host_to_chip_port[3] <= 8'd0;
        end
        boot_rom_enable <= in_wd[7];
      end
      if (is_wr && page) begin
        case (reg_sel) inside
          acit_pkg::REG_DSP_ADR: dsp_address <= in_wd;
          acit_pkg::REG_PORT0, acit_pkg::REG_PORT1,
          acit_pkg::REG_PORT2, acit_pkg::REG_PORT3:
            chip_to_host_port[reg_sel[1:0]] <= in_wd;
          acit_pkg::REG_AUX0: aux_byte[0] <= in_wd;
          acit_pkg::REG_AUX1: aux_byte[1] <= in_wd;
          default: ;
        endcase
      end
      if (is_hw) begin
        host_to_chip_port[in_port] <= in_wd;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m_tdata <= result;
    end
  end

`ifndef ASSERT_OFF
  // input stalls only when a held item waits behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && m_tvalid && !m_tready))
    else $error("input stalled without a blocked result");

  // a retired item always shows up as a result
  a_retire_result: assert property (@(posedge clk) disable iff (rst)
    go |=> m_tvalid)
    else $error("retired item produced no result");

  // dsp writes come only from the register page and take processor time
  a_dsp_write_page: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[17]) |-> (m_tdata[8] && (m_tdata[16:12] != 5'd0)))
    else $error("dsp write outside the register page");

  // forced ram reads carry the fill pattern and never hit the page
  a_forced_read: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[10]) |-> ((m_tdata[7:0] == acit_pkg::RAM_FILL) && !m_tdata[8]))
    else $error("forced ram read with wrong data or page hit");
`endif

endmodule
